// File: rtl/core/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

    // fixed field widths
    localparam int TASK_W  = 4;
    localparam int TIME_W  = 32;
    localparam int QUANT_W = 16;

    // action codes on the input item
    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_SLICE,
        ST_RUN
    } rrts_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic arrive;
        logic slice;
        logic run;
    } rrts_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/rrts_ram.sv
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/rrts_ctrl.sv
`default_nettype none

module rrts_ctrl
    import rrts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      action,
    output logic           busy,
    output logic           strobe,
    output rrts_cmd_t      cmd
);

    rrts_state_t state_reg;
    rrts_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (action == ACT_TICK) ? ST_SLICE : ST_ARRIVE;
                end
            end
            ST_ARRIVE: state_next = ST_IDLE;
            ST_SLICE:  state_next = ST_RUN;
            ST_RUN:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy        = 1'b1;
        strobe      = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_ARRIVE:
            begin
                cmd.arrive = 1'b1;
                strobe     = 1'b1;
            end
            ST_SLICE:
            begin
                cmd.slice = 1'b1;
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
                strobe  = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/rrts_datapath.sv
`default_nettype none

module rrts_datapath
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS  = 16,
    parameter int BURST_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rrts_cmd_t             cmd,
    input  wire logic [TASK_W-1:0]     task_id,
    input  wire logic [BURST_BITS-1:0] burst,
    input  wire logic                  cfg_we,
    input  wire logic [QUANT_W-1:0]    cfg_wdata,
    output logic                       accepted,
    output logic                       run_valid,
    output logic [TASK_W-1:0]          run_task,
    output logic                       slice_end,
    output logic                       done_valid,
    output logic [TASK_W-1:0]          done_task,
    output logic [TIME_W-1:0]          done_time,
    output logic [TIME_W-1:0]          turnaround,
    output logic [TIME_W-1:0]          wait_time,
    output logic                       idle,
    output logic [TIME_W-1:0]          switch_count
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int EW = TASK_W + 2 * BURST_BITS + TIME_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_TASKS - 1);
    localparam logic [CW:0] OCC_MAX = (CW + 1)'(MAX_TASKS);

    // captured arrival payload
    logic [TASK_W-1:0]     task_in_reg;
    logic [BURST_BITS-1:0] burst_in_reg;

    // configuration and scheduler state
    logic [QUANT_W-1:0]    quantum_reg, quantum_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [IW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  running_reg, running_next;
    logic [TASK_W-1:0]     cur_task_reg, cur_task_next;
    logic [BURST_BITS-1:0] cur_rem_reg, cur_rem_next;
    logic [TIME_W-1:0]     cur_arr_reg, cur_arr_next;
    logic [BURST_BITS-1:0] cur_burst_reg, cur_burst_next;
    logic [QUANT_W-1:0]    slice_used_reg, slice_used_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [TIME_W-1:0]     dispatches_reg, dispatches_next;
    logic                  load_reg, load_next;

    // tick results held from the slice step to the run step
    logic                  slice_end_reg, slice_end_next;
    logic                  done_valid_reg, done_valid_next;
    logic [TASK_W-1:0]     done_task_reg, done_task_next;
    logic [TIME_W-1:0]     done_time_reg, done_time_next;
    logic [TIME_W-1:0]     tat_reg, tat_next;
    logic [TIME_W-1:0]     wait_reg, wait_next;
    logic                  idle_reg, idle_next;

    // queue memory
    logic                  wr_en;
    logic [EW-1:0]         wr_data;
    logic [EW-1:0]         rd_data;
    logic [TASK_W-1:0]     rd_task;
    logic [BURST_BITS-1:0] rd_rem;
    logic [TIME_W-1:0]     rd_arr;
    logic [BURST_BITS-1:0] rd_burst;

    // decisions
    logic                  room;
    logic                  rem_zero;
    logic                  end_slice;
    logic                  finished;
    logic                  requeue;
    logic                  free;
    logic                  queue_empty;
    logic                  keep_same;
    logic                  load;
    logic                  run_active;
    logic [TASK_W-1:0]     eff_task;
    logic [BURST_BITS-1:0] eff_rem;
    logic [TIME_W-1:0]     tat;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
        return (i == LAST_SLOT) ? '0 : i + 1'b1;
    endfunction

    rrts_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS)
    ) u_queue (
        .clk   (clk),
        .we    (wr_en),
        .waddr (tail_reg),
        .wdata (wr_data),
        .raddr (head_reg),
        .rdata (rd_data)
    );

    assign {rd_task, rd_rem, rd_arr, rd_burst} = rd_data;

    // slice end and dispatch decisions
    assign room        = ({1'b0, count_reg} + (CW + 1)'(running_reg)) < OCC_MAX;
    assign rem_zero    = (cur_rem_reg == '0);
    assign end_slice   = running_reg && (rem_zero || (slice_used_reg >= quantum_reg));
    assign finished    = end_slice && rem_zero;
    assign requeue     = end_slice && !rem_zero;
    assign free        = !running_reg || end_slice;
    assign queue_empty = (count_reg == '0);
    // preempted task with nothing queued is dispatched again in place
    assign keep_same   = requeue && queue_empty;
    assign load        = free && !queue_empty;
    assign tat         = now_reg - cur_arr_reg;

    // run step works on the freshly loaded task when a dispatch is pending
    assign run_active  = running_reg || load_reg;
    assign eff_task    = load_reg ? rd_task : cur_task_reg;
    assign eff_rem     = load_reg ? rd_rem : cur_rem_reg;

    // queue writes: arrivals and requeued tasks
    assign wr_en   = (cmd.arrive && room) || (cmd.slice && requeue && !queue_empty);
    assign wr_data = cmd.arrive ? {task_in_reg, burst_in_reg, now_reg, burst_in_reg}
                                : {cur_task_reg, cur_rem_reg, cur_arr_reg, cur_burst_reg};

    // next state
    always_comb
    begin
        quantum_next    = quantum_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        running_next    = running_reg;
        cur_task_next   = cur_task_reg;
        cur_rem_next    = cur_rem_reg;
        cur_arr_next    = cur_arr_reg;
        cur_burst_next  = cur_burst_reg;
        slice_used_next = slice_used_reg;
        now_next        = now_reg;
        dispatches_next = dispatches_reg;
        load_next       = load_reg;
        slice_end_next  = slice_end_reg;
        done_valid_next = done_valid_reg;
        done_task_next  = done_task_reg;
        done_time_next  = done_time_reg;
        tat_next        = tat_reg;
        wait_next       = wait_reg;
        idle_next       = idle_reg;

        if (cfg_we)
        begin
            quantum_next = cfg_wdata;
        end

        // arrival
        if (cmd.arrive && room)
        begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + 1'b1;
        end

        // slice end and dispatch
        if (cmd.slice)
        begin
            slice_end_next  = end_slice;
            done_valid_next = finished;
            done_task_next  = finished ? cur_task_reg : '0;
            done_time_next  = finished ? now_reg : '0;
            tat_next        = finished ? tat : '0;
            wait_next       = finished ? (tat - TIME_W'(cur_burst_reg)) : '0;
            idle_next       = free && queue_empty && !requeue;
            load_next       = load;
            running_next    = (running_reg && !end_slice) || keep_same;
            if (requeue && !queue_empty)
            begin
                tail_next = next_slot(tail_reg);
            end
            if (load)
            begin
                head_next = next_slot(head_reg);
                if (!requeue)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            if (load || keep_same)
            begin
                dispatches_next = dispatches_reg + 1'b1;
                slice_used_next = '0;
            end
        end

        // run one unit and advance time
        if (cmd.run)
        begin
            if (load_reg)
            begin
                cur_task_next  = rd_task;
                cur_rem_next   = rd_rem;
                cur_arr_next   = rd_arr;
                cur_burst_next = rd_burst;
                running_next   = 1'b1;
            end
            if (run_active)
            begin
                if (eff_rem != '0)
                begin
                    cur_rem_next = eff_rem - 1'b1;
                end
                if (slice_used_reg != '1)
                begin
                    slice_used_next = slice_used_reg + 1'b1;
                end
            end
            now_next  = now_reg + 1'b1;
            load_next = 1'b0;
        end
    end

    // arrival payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            task_in_reg  <= task_id;
            burst_in_reg <= burst;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg    <= QUANT_W'(4);
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            running_reg    <= 1'b0;
            cur_task_reg   <= '0;
            cur_rem_reg    <= '0;
            cur_arr_reg    <= '0;
            cur_burst_reg  <= '0;
            slice_used_reg <= '0;
            now_reg        <= '0;
            dispatches_reg <= '0;
            load_reg       <= 1'b0;
            slice_end_reg  <= 1'b0;
            done_valid_reg <= 1'b0;
            done_task_reg  <= '0;
            done_time_reg  <= '0;
            tat_reg        <= '0;
            wait_reg       <= '0;
            idle_reg       <= 1'b0;
        end
        else
        begin
            quantum_reg    <= quantum_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            running_reg    <= running_next;
            cur_task_reg   <= cur_task_next;
            cur_rem_reg    <= cur_rem_next;
            cur_arr_reg    <= cur_arr_next;
            cur_burst_reg  <= cur_burst_next;
            slice_used_reg <= slice_used_next;
            now_reg        <= now_next;
            dispatches_reg <= dispatches_next;
            load_reg       <= load_next;
            slice_end_reg  <= slice_end_next;
            done_valid_reg <= done_valid_next;
            done_task_reg  <= done_task_next;
            done_time_reg  <= done_time_next;
            tat_reg        <= tat_next;
            wait_reg       <= wait_next;
            idle_reg       <= idle_next;
        end
    end

    // result fields, zero where they do not apply
    assign accepted     = cmd.arrive && room;
    assign run_valid    = cmd.run && run_active && (eff_rem != '0);
    assign run_task     = run_valid ? eff_task : '0;
    assign slice_end    = cmd.run && slice_end_reg;
    assign done_valid   = cmd.run && done_valid_reg;
    assign done_task    = done_valid ? done_task_reg : '0;
    assign done_time    = done_valid ? done_time_reg : '0;
    assign turnaround   = done_valid ? tat_reg : '0;
    assign wait_time    = done_valid ? wait_reg : '0;
    assign idle         = cmd.run && idle_reg;
    assign switch_count = dispatches_reg;

endmodule

`default_nettype wire

// File: rtl/core/round_robin_time_slice_scheduler.sv
`default_nettype none
// round-robin time-slice scheduler
// arrive: result strobed in the cycle after the start transfer; busy until it is out, no new item taken
// tick: result strobed in the run state, which follows the slice state entered on the start transfer;
//   busy in both; the split allows the registered read of the ready-queue memory on a dispatch
// results are strobed for one cycle, the receiver cannot stall
// async active-low reset: queue empty, nothing running, time and counts zero, quantum 4

module round_robin_time_slice_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS  = 16,
    parameter int BURST_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  action,
    input  wire logic [TASK_W-1:0]     task_id,
    input  wire logic [BURST_BITS-1:0] burst,
    input  wire logic                  cfg_we,
    input  wire logic [QUANT_W-1:0]    cfg_wdata,
    output logic                       strobe,
    output logic                       accepted,
    output logic                       run_valid,
    output logic [TASK_W-1:0]          run_task,
    output logic                       slice_end,
    output logic                       done_valid,
    output logic [TASK_W-1:0]          done_task,
    output logic [TIME_W-1:0]          done_time,
    output logic [TIME_W-1:0]          turnaround,
    output logic [TIME_W-1:0]          wait_time,
    output logic                       idle,
    output logic [TIME_W-1:0]          switch_count
);

    rrts_cmd_t cmd;

    // sequencer
    rrts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .strobe (strobe),
        .cmd    (cmd)
    );

    // queue, running task and counters
    rrts_datapath #(
        .MAX_TASKS  (MAX_TASKS),
        .BURST_BITS (BURST_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .task_id      (task_id),
        .burst        (burst),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .accepted     (accepted),
        .run_valid    (run_valid),
        .run_task     (run_task),
        .slice_end    (slice_end),
        .done_valid   (done_valid),
        .done_task    (done_task),
        .done_time    (done_time),
        .turnaround   (turnaround),
        .wait_time    (wait_time),
        .idle         (idle),
        .switch_count (switch_count)
    );

endmodule

`default_nettype wire
